// ===== src/bma_pkg.sv =====
// Package for the buddy allocator: item types, status codes, register indexes
// and controller states. No dependencies.
`timescale 1ns / 1ps

package bma_pkg;

  localparam int AddrW = 20;
  localparam int OrdW  = 4;

  // Configuration register indexes.
  localparam logic CFG_BBL = 1'b0;
  localparam logic CFG_HDR = 1'b1;

  // Operation codes.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_BLOCK  = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_e;

  typedef struct packed {
    logic             kind;
    logic [AddrW-1:0] request_length;
    logic [AddrW-1:0] block_address;
  } req_t;

  typedef struct packed {
    logic [AddrW-1:0] result_address;
    logic [OrdW-1:0]  result_order;
    logic [1:0]       status;
  } rsp_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_SEARCH,
    S_SPLIT,
    S_TAGRD,
    S_TAGCHK,
    S_MERGE_RD,
    S_MERGE_CK,
    S_DONE
  } state_e;

endpackage

// ===== src/buddy_memory_allocator.sv =====
// Binary buddy allocator over a region of basic blocks.
//
// Usage: an item on the in channel is an allocate or a free; each gives exactly
// one result item on the out channel. Both channels use valid and stall, and an
// item moves at a clock edge with valid high and stall low. The config port
// writes basic_block_log2 (index 0) or header_bytes (index 1) while idle; the
// user is bound to this, as the block itself does not enforce it. A free reads
// and checks the block's tag, then reads and checks the buddy at each merge
// level until the merge stops at a busy buddy or the top; an allocate scans
// free-list nodes from the requested order up to the first free node, one node
// per read, then splits level by level. One item is in work at a time.
// The result goes to an output register, so the next item is taken while a
// finished result waits under stall; a held result stops only the item after.
// Reset: a clearing pass over every tree node writes the free-flag and tag
// memories; in_stall_o stays high during it. Config writes work throughout.
// Depends on bma_pkg, bma_ram and bma_ctrl.
`timescale 1ns / 1ps

module buddy_memory_allocator #(
  parameter int UNITS     = 256,
  parameter int MAX_ORDER = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [6:0]    cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bma_pkg::req_t in_item_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bma_pkg::rsp_t out_item_o
);

  logic [3:0] bbl_q;
  logic [6:0] hdr_q;

  logic                 flag_we, flag_wdata, flag_rdata;
  logic [MAX_ORDER:0]   flag_waddr, flag_raddr;
  logic                 tag_we;
  logic [MAX_ORDER-1:0] tag_waddr, tag_raddr;
  logic [4:0]           tag_wdata, tag_rdata;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bbl_q <= 4'd7;
      hdr_q <= 7'd16;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == bma_pkg::CFG_BBL) bbl_q <= cfg_data_i[3:0];
      else hdr_q <= cfg_data_i;
    end
  end

  // Free flag per tree node.
  bma_ram #(.DW(1), .AW(MAX_ORDER + 1)) u_flags (
    .clk_i   (clk_i),
    .we_i    (flag_we),
    .waddr_i (flag_waddr),
    .wdata_i (flag_wdata),
    .raddr_i (flag_raddr),
    .rdata_o (flag_rdata)
  );

  // Allocation tag per basic block.
  bma_ram #(.DW(5), .AW(MAX_ORDER)) u_tags (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (tag_wdata),
    .raddr_i (tag_raddr),
    .rdata_o (tag_rdata)
  );

  bma_ctrl #(.UNITS(UNITS), .MAX_ORDER(MAX_ORDER)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .bbl_i        (bbl_q),
    .hdr_i        (hdr_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o),
    .flag_we_o    (flag_we),
    .flag_waddr_o (flag_waddr),
    .flag_wdata_o (flag_wdata),
    .flag_raddr_o (flag_raddr),
    .flag_rdata_i (flag_rdata),
    .tag_we_o     (tag_we),
    .tag_waddr_o  (tag_waddr),
    .tag_wdata_o  (tag_wdata),
    .tag_raddr_o  (tag_raddr),
    .tag_rdata_i  (tag_rdata)
  );

endmodule

// ===== src/bma_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module bma_ram #(
  parameter int DW = 1,
  parameter int AW = 9
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== src/bma_ctrl.sv =====
// Sequencer of the buddy allocator: clearing pass, free-block search, split
// and merge walks, result register. Depends on bma_pkg.
`timescale 1ns / 1ps

module bma_ctrl #(
  parameter int UNITS     = 256,
  parameter int MAX_ORDER = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [3:0]           bbl_i,
  input  logic [6:0]           hdr_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bma_pkg::req_t        in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bma_pkg::rsp_t        out_item_o,
  output logic                 flag_we_o,
  output logic [MAX_ORDER:0]   flag_waddr_o,
  output logic                 flag_wdata_o,
  output logic [MAX_ORDER:0]   flag_raddr_o,
  input  logic                 flag_rdata_i,
  output logic                 tag_we_o,
  output logic [MAX_ORDER-1:0] tag_waddr_o,
  output logic [4:0]           tag_wdata_o,
  output logic [MAX_ORDER-1:0] tag_raddr_o,
  input  logic [4:0]           tag_rdata_i
);

  localparam int IW  = MAX_ORDER;
  localparam int NAW = MAX_ORDER + 1;
  localparam int Lim = (UNITS < (2 ** MAX_ORDER)) ? UNITS : (2 ** MAX_ORDER);
  localparam logic [NAW-1:0] LimV = NAW'(Lim);
  localparam logic [3:0] MOrd = 4'(MAX_ORDER);

  // Flat node address of (order, index).
  function automatic logic [NAW-1:0] node_of(input logic [3:0] ord, input logic [IW-1:0] idx);
    logic [NAW-1:0] base;
    base = (NAW'(1) << (MOrd - ord)) - NAW'(1);
    return base + NAW'(idx);
  endfunction

  // Highest node index at an order.
  function automatic logic [IW-1:0] last_idx(input logic [3:0] ord);
    logic [NAW-1:0] n;
    n = (NAW'(1) << (MOrd - ord)) - NAW'(1);
    return n[IW-1:0];
  endfunction

  bma_pkg::state_e state_q, state_d;
  bma_pkg::req_t   req_q, req_d;
  bma_pkg::rsp_t   rsp_q, rsp_d, out_q, out_d;
  logic            out_vld_q, out_vld_d;
  logic [3:0]      k_q, k_d;       // requested order
  logic [3:0]      o_q, o_d;       // walking order
  logic [IW-1:0]   i_q, i_d;       // walking index
  logic            s_act_q, s_act_d;
  logic            pend_q, pend_d;
  logic [3:0]      p_ord_q, p_ord_d;
  logic [IW-1:0]   p_idx_q, p_idx_d;
  logic [IW-1:0]   unit_q, unit_d;

  // Shared decode terms.
  logic [20:0]    need;
  logic [3:0]     ksel;
  logic           kfit;
  logic [19:0]    start;
  logic [19:0]    unit_full;
  logic           free_bad;
  logic [NAW-1:0] lim_sh;
  logic           init_free;
  logic           init_end;
  logic           out_free;
  logic [IW-1:0]  bud;
  logic           bud_ok;
  logic [NAW-1:0] bud_top;
  logic           found;
  logic [3:0]     tag_ord;

  // Smallest order whose block holds length plus header.
  always_comb begin
    need = 21'(req_q.request_length) + 21'(hdr_i);
    ksel = 4'd0;
    kfit = 1'b0;
    for (int k = MAX_ORDER; k >= 0; k--) begin
      if ((33'(1) << (k + int'(bbl_i))) >= 33'(need)) begin
        ksel = 4'(k);
        kfit = 1'b1;
      end
    end
  end

  // Validity of a freed address.
  always_comb begin
    start     = req_q.block_address - 20'(hdr_i);
    unit_full = start >> bbl_i;
    free_bad  = (req_q.block_address < 20'(hdr_i)) ||
                ((start & ~(20'hFFFFF << bbl_i)) != 20'd0) ||
                (unit_full >= 20'(Lim));
  end

  // Reset pattern: largest aligned blocks covering the region.
  always_comb begin
    lim_sh    = LimV >> o_q;
    init_free = lim_sh[0] && ({1'b0, i_q} == {lim_sh[NAW-1:1], 1'b0});
    init_end  = (i_q == last_idx(o_q)) && (o_q == MOrd);
  end

  // Walk terms.
  always_comb begin
    out_free = !out_vld_q || !out_stall_i;
    bud      = i_q ^ IW'(1);
    bud_top  = (NAW'(bud) + NAW'(1)) << o_q;
    bud_ok   = (o_q < MOrd) && (bud_top <= LimV);
    found    = pend_q && flag_rdata_i;
    tag_ord  = (tag_rdata_i[3:0] > MOrd) ? MOrd : tag_rdata_i[3:0];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bma_pkg::S_INIT:   if (init_end) state_d = bma_pkg::S_IDLE;
      bma_pkg::S_IDLE:   if (in_valid_i) state_d = bma_pkg::S_DECODE;
      bma_pkg::S_DECODE: begin
        if (req_q.kind == bma_pkg::KIND_FREE) begin
          state_d = free_bad ? bma_pkg::S_DONE : bma_pkg::S_TAGRD;
        end else begin
          state_d = kfit ? bma_pkg::S_SEARCH : bma_pkg::S_DONE;
        end
      end
      bma_pkg::S_SEARCH: begin
        if (found) state_d = bma_pkg::S_SPLIT;
        else if (!s_act_q && !pend_q) state_d = bma_pkg::S_DONE;
      end
      bma_pkg::S_SPLIT:    if (o_q <= k_q) state_d = bma_pkg::S_DONE;
      bma_pkg::S_TAGRD:    state_d = bma_pkg::S_TAGCHK;
      bma_pkg::S_TAGCHK:   state_d = tag_rdata_i[4] ? bma_pkg::S_MERGE_RD : bma_pkg::S_DONE;
      bma_pkg::S_MERGE_RD: state_d = bud_ok ? bma_pkg::S_MERGE_CK : bma_pkg::S_DONE;
      bma_pkg::S_MERGE_CK: state_d = flag_rdata_i ? bma_pkg::S_MERGE_RD : bma_pkg::S_DONE;
      bma_pkg::S_DONE:     if (out_free) state_d = bma_pkg::S_IDLE;
      default:             state_d = bma_pkg::S_INIT;
    endcase
  end

  // Datapath, memory ports and result.
  always_comb begin
    req_d     = req_q;
    rsp_d     = rsp_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && out_stall_i;
    k_d       = k_q;
    o_d       = o_q;
    i_d       = i_q;
    s_act_d   = s_act_q;
    pend_d    = 1'b0;
    p_ord_d   = p_ord_q;
    p_idx_d   = p_idx_q;
    unit_d    = unit_q;
    flag_we_o    = 1'b0;
    flag_waddr_o = node_of(o_q, i_q);
    flag_wdata_o = 1'b0;
    flag_raddr_o = node_of(o_q, i_q);
    tag_we_o     = 1'b0;
    tag_waddr_o  = unit_q;
    tag_wdata_o  = 5'd0;
    tag_raddr_o  = unit_q;
    in_stall_o   = (state_q != bma_pkg::S_IDLE);

    unique case (state_q)
      // Clearing pass: one node a cycle, tags alongside order zero.
      bma_pkg::S_INIT: begin
        flag_we_o    = 1'b1;
        flag_wdata_o = init_free;
        tag_we_o     = (o_q == 4'd0);
        tag_waddr_o  = i_q;
        if (i_q == last_idx(o_q)) begin
          i_d = '0;
          o_d = (o_q == MOrd) ? 4'd0 : o_q + 4'd1;
        end else begin
          i_d = i_q + IW'(1);
        end
      end
      bma_pkg::S_IDLE: begin
        if (in_valid_i) req_d = in_item_i;
      end
      bma_pkg::S_DECODE: begin
        rsp_d = '0;
        if (req_q.kind == bma_pkg::KIND_FREE) begin
          rsp_d.status = free_bad ? bma_pkg::ST_BAD_FREE : bma_pkg::ST_OK;
          unit_d       = unit_full[IW-1:0];
        end else begin
          rsp_d.status = kfit ? bma_pkg::ST_OK : bma_pkg::ST_TOO_LARGE;
          k_d     = ksel;
          o_d     = ksel;
          i_d     = '0;
          s_act_d = 1'b1;
        end
      end
      // Scan orders upward, lowest index first, one read in flight.
      bma_pkg::S_SEARCH: begin
        if (found) begin
          flag_we_o    = 1'b1;
          flag_waddr_o = node_of(p_ord_q, p_idx_q);
          o_d          = p_ord_q;
          i_d          = p_idx_q;
          s_act_d      = 1'b0;
        end else begin
          if (!s_act_q && !pend_q) rsp_d.status = bma_pkg::ST_NO_BLOCK;
          if (s_act_q) begin
            pend_d  = 1'b1;
            p_ord_d = o_q;
            p_idx_d = i_q;
            if (i_q == last_idx(o_q)) begin
              i_d = '0;
              if (o_q == MOrd) s_act_d = 1'b0;
              else o_d = o_q + 4'd1;
            end else begin
              i_d = i_q + IW'(1);
            end
          end
        end
      end
      // Split down, freeing each upper half, then tag the block.
      bma_pkg::S_SPLIT: begin
        if (o_q > k_q) begin
          flag_we_o    = 1'b1;
          flag_wdata_o = 1'b1;
          flag_waddr_o = node_of(o_q - 4'd1, (i_q << 1) | IW'(1));
          o_d          = o_q - 4'd1;
          i_d          = i_q << 1;
        end else begin
          tag_we_o    = 1'b1;
          tag_waddr_o = i_q << k_q;
          tag_wdata_o = {1'b1, k_q};
          rsp_d.result_address = (20'(i_q << k_q) << bbl_i) + 20'(hdr_i);
          rsp_d.result_order   = k_q;
        end
      end
      bma_pkg::S_TAGRD: ;
      bma_pkg::S_TAGCHK: begin
        if (tag_rdata_i[4]) begin
          tag_we_o = 1'b1;
          o_d      = tag_ord;
          i_d      = unit_q >> tag_ord;
        end else begin
          rsp_d.status = bma_pkg::ST_BAD_FREE;
        end
      end
      bma_pkg::S_MERGE_RD: begin
        flag_raddr_o = node_of(o_q, bud);
        if (!bud_ok) begin
          flag_we_o          = 1'b1;
          flag_wdata_o       = 1'b1;
          rsp_d.result_order = o_q;
        end
      end
      bma_pkg::S_MERGE_CK: begin
        flag_we_o = 1'b1;
        if (flag_rdata_i) begin
          flag_waddr_o = node_of(o_q, bud);
          i_d          = i_q >> 1;
          o_d          = o_q + 4'd1;
        end else begin
          flag_wdata_o       = 1'b1;
          rsp_d.result_order = o_q;
        end
      end
      bma_pkg::S_DONE: begin
        if (out_free) begin
          out_d     = rsp_q;
          out_vld_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bma_pkg::S_INIT;
      out_vld_q <= 1'b0;
      o_q       <= 4'd0;
      i_q       <= '0;
      s_act_q   <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      o_q       <= o_d;
      i_q       <= i_d;
      s_act_q   <= s_act_d;
      pend_q    <= pend_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    rsp_q   <= rsp_d;
    out_q   <= out_d;
    k_q     <= k_d;
    p_ord_q <= p_ord_d;
    p_idx_q <= p_idx_d;
    unit_q  <= unit_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule
